// ===== src/e2bmw_pkg.sv =====
`timescale 1ns / 1ps
package e2bmw_pkg;

	localparam int DIRECT_SLOTS_DEF = 12;
	localparam int GROUP_DESC_BYTES_DEF = 32;
	localparam int MAX_BLOCK_BYTES_DEF = 4096;

	localparam logic [43:0] GD_TABLE_WORD_OFFSET = 44'd8;
	localparam logic [43:0] INODE_SLOTS_OFFSET = 44'd40;

	localparam logic [1:0] K_READ = 2'd0;
	localparam logic [1:0] K_DONE = 2'd1;
	localparam logic [1:0] K_ERR = 2'd2;
	localparam logic [1:0] K_RANGE = 2'd3;

	localparam logic [1:0] REG_BLOCK_SIZE_LOG2 = 2'd0;
	localparam logic [1:0] REG_INODES_PER_GROUP = 2'd1;
	localparam logic [1:0] REG_INODE_RECORD_BYTES = 2'd2;
	localparam logic [1:0] REG_FIRST_DATA_BLOCK = 2'd3;

	typedef struct packed {
		logic        action;
		logic [31:0] ino_num;
		logic [31:0] file_block;
		logic [31:0] read_word;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [43:0] read_address;
		logic [31:0] volume_block;
	} out_item_t;

	// classified job handed from front to back
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] ino_idx;
		logic [31:0] word;
		logic [31:0] rem;
		logic [3:0]  slot;
		logic [1:0]  levels;
	} job_t;

	localparam logic [2:0] OP_ERR = 3'd0;
	localparam logic [2:0] OP_RANGE = 3'd1;
	localparam logic [2:0] OP_START = 3'd2;
	localparam logic [2:0] OP_GROUP = 3'd3;
	localparam logic [2:0] OP_WORD = 3'd4;

endpackage

// ===== src/e2bmw_front.sv =====
`timescale 1ns / 1ps
module e2bmw_front #(
	parameter int DIRECT_SLOTS = e2bmw_pkg::DIRECT_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  e2bmw_pkg::in_item_t  item,
	input  logic [3:0]           bl,
	input  logic                 walking,
	output e2bmw_pkg::job_t      job
);
	logic [4:0]  cl;
	logic [33:0] r, n1, n2, n3;
	e2bmw_pkg::job_t j;

	assign cl = 5'(bl) - 5'd2;

	always_comb begin
		n1 = 34'd1 << cl;
		n2 = n1 << cl;
		n3 = n2 << cl;
		r = 34'(item.file_block) - 34'(DIRECT_SLOTS);
		j = '0;
		j.ino_idx = item.ino_num - 32'd1;
		j.word = item.read_word;
		if (item.action) begin
			j.op = e2bmw_pkg::OP_WORD;
		end else if (walking || item.ino_num == 32'd0) begin
			j.op = e2bmw_pkg::OP_ERR;
		end else if (item.file_block < 32'(DIRECT_SLOTS)) begin
			j.op = e2bmw_pkg::OP_START;
			j.slot = item.file_block[3:0];
		end else if (r < n1) begin
			j.op = e2bmw_pkg::OP_START;
			j.slot = 4'(DIRECT_SLOTS);
			j.levels = 2'd1;
			j.rem = r[31:0];
		end else if (r - n1 < n2) begin
			j.op = e2bmw_pkg::OP_START;
			j.slot = 4'(DIRECT_SLOTS + 1);
			j.levels = 2'd2;
			j.rem = 32'(r - n1);
		end else if (r - n1 - n2 < n3) begin
			j.op = e2bmw_pkg::OP_START;
			j.slot = 4'(DIRECT_SLOTS + 2);
			j.levels = 2'd3;
			j.rem = 32'(r - n1 - n2);
		end else begin
			j.op = e2bmw_pkg::OP_RANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job <= '0;
		end else if (take) begin
			job <= j;
		end
	end
endmodule

// ===== src/e2bmw_back.sv =====
`timescale 1ns / 1ps
module e2bmw_back #(
	parameter int GROUP_DESC_BYTES = e2bmw_pkg::GROUP_DESC_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  e2bmw_pkg::job_t      job,
	input  logic [3:0]           bl,
	input  logic [31:0]          ipg,
	input  logic [12:0]          rec_bytes,
	input  logic                 fdb,
	output logic                 busy,
	output logic                 walking,
	output logic                 strobe,
	output e2bmw_pkg::out_item_t result
);
	typedef enum logic [2:0] {IDLE, DIV, EMIT_GRP, WAIT_GRP, WAIT_WORD} ph_t;
	ph_t ph_q;
	logic [31:0] quo_q, rem_q, den_q, rix_q;
	logic [5:0]  cnt_q;
	logic [3:0]  slot_q;
	logic [1:0]  lv_q;
	logic [32:0] trial;
	logic [4:0]  cl;
	logic [1:0]  lvn;
	logic [31:0] idx;
	logic [63:0] prod;

	assign cl = 5'(bl) - 5'd2;
	assign lvn = lv_q - 2'd1;
	assign idx = (rix_q >> (6'(cl) * 6'(lvn))) & ((32'd1 << cl) - 32'd1);
	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};
	assign prod = 64'(rem_q) * 64'(rec_bytes);
	assign busy = ph_q == DIV || ph_q == EMIT_GRP;
	assign walking = ph_q != IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= IDLE;
			strobe <= 1'b0;
			result <= '0;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			lv_q <= '0;
			slot_q <= '0;
			rix_q <= '0;
			cnt_q <= '0;
		end else begin
			strobe <= 1'b0;
			result <= '0;
			unique case (ph_q)
				DIV: begin
					quo_q <= {quo_q[30:0], ~trial[32]};
					rem_q <= trial[32] ? {rem_q[30:0], quo_q[31]} : trial[31:0];
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) ph_q <= EMIT_GRP;
				end
				EMIT_GRP: begin
					strobe <= 1'b1;
					result.kind <= e2bmw_pkg::K_READ;
					result.read_address <= (44'({1'b0, fdb} + 2'd1) << bl)
						+ 44'(quo_q) * 44'(GROUP_DESC_BYTES)
						+ e2bmw_pkg::GD_TABLE_WORD_OFFSET;
					ph_q <= WAIT_GRP;
				end
				default: begin
					if (go) begin
						strobe <= 1'b1;
						if (job.op == e2bmw_pkg::OP_START) begin
							quo_q <= job.ino_idx;
							rem_q <= '0;
							den_q <= (ipg == 32'd0) ? 32'd1 : ipg;
							cnt_q <= 6'd32;
							slot_q <= job.slot;
							lv_q <= job.levels;
							rix_q <= job.rem;
							strobe <= 1'b0;
							ph_q <= DIV;
						end else if (job.op == e2bmw_pkg::OP_RANGE) begin
							result.kind <= e2bmw_pkg::K_RANGE;
						end else if (job.op == e2bmw_pkg::OP_WORD && ph_q == WAIT_GRP) begin
							result.kind <= e2bmw_pkg::K_READ;
							result.read_address <= (44'(job.word) << bl) + prod[43:0]
								+ e2bmw_pkg::INODE_SLOTS_OFFSET + 44'({slot_q, 2'b00});
							ph_q <= WAIT_WORD;
						end else if (job.op == e2bmw_pkg::OP_WORD && ph_q == WAIT_WORD) begin
							if (lv_q == 2'd0) begin
								result.kind <= e2bmw_pkg::K_DONE;
								result.volume_block <= job.word;
								ph_q <= IDLE;
							end else begin
								lv_q <= lvn;
								result.kind <= e2bmw_pkg::K_READ;
								result.read_address <= (44'(job.word) << bl)
									+ 44'({idx, 2'b00});
							end
						end else begin
							result.kind <= e2bmw_pkg::K_ERR;
						end
					end
				end
			endcase
		end
	end
endmodule

// ===== src/ext2_block_map_walker.sv =====
`timescale 1ns / 1ps
// ext2 block map walker: start a request (translate or returned read word) when busy is low;
// each request gives one result, strobed for one cycle, that the receiver must take then.
// a translate request is classified and registered, then a radix-2 divider splits the inode
// number by inodes per group; busy stays high until the group read is emitted; every
// other request passes the classifier's job register and the walker's result register without
// the divider, and busy is high only while its job is queued
module ext2_block_map_walker #(
	parameter int DIRECT_SLOTS = e2bmw_pkg::DIRECT_SLOTS_DEF,
	parameter int GROUP_DESC_BYTES = e2bmw_pkg::GROUP_DESC_BYTES_DEF,
	parameter int MAX_BLOCK_BYTES = e2bmw_pkg::MAX_BLOCK_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  e2bmw_pkg::in_item_t  request,
	output logic                 strobe,
	output e2bmw_pkg::out_item_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	// largest block size log2 that still fits in the maximum block size
	localparam logic [3:0] MAX_LOG2 = 4'($clog2(MAX_BLOCK_BYTES + 1) - 1);

	// configuration registers
	logic [3:0]  bsl_q;
	logic [31:0] ipg_q;
	logic [12:0] rec_q;
	logic        fdb_q;
	logic [3:0]  bl;
	// single-entry queue between classifier and walker
	logic            go_q;
	logic            back_busy, walking;
	e2bmw_pkg::job_t job;
	logic            take;

	assign cfg_ready = 1'b1;
	assign bl = (bsl_q < 4'd10) ? 4'd10 : (bsl_q > MAX_LOG2) ? MAX_LOG2 : bsl_q;
	// hold off while the queue is full, the divider runs or the group read is emitted
	assign busy = go_q || back_busy;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsl_q <= 4'd10;
			ipg_q <= 32'd8192;
			rec_q <= 13'd128;
			fdb_q <= 1'b1;
			go_q <= 1'b0;
		end else begin
			go_q <= take;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					e2bmw_pkg::REG_BLOCK_SIZE_LOG2: bsl_q <= cfg_data[3:0];
					e2bmw_pkg::REG_INODES_PER_GROUP: ipg_q <= cfg_data;
					e2bmw_pkg::REG_INODE_RECORD_BYTES: rec_q <= cfg_data[12:0];
					e2bmw_pkg::REG_FIRST_DATA_BLOCK: fdb_q <= cfg_data[0];
				endcase
			end
		end
	end

	e2bmw_front #(.DIRECT_SLOTS(DIRECT_SLOTS)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .item(request), .bl(bl),
		.walking(walking), .job(job)
	);

	e2bmw_back #(.GROUP_DESC_BYTES(GROUP_DESC_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .go(go_q), .job(job), .bl(bl), .ipg(ipg_q),
		.rec_bytes(rec_q), .fdb(fdb_q), .busy(back_busy), .walking(walking),
		.strobe(strobe), .result(result)
	);
endmodule

// ===== src/e2bmw_checker.sv =====
`timescale 1ns / 1ps
module e2bmw_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 strobe,
	input e2bmw_pkg::out_item_t result
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind != e2bmw_pkg::K_READ |-> result.read_address == 44'd0)
		else $error("address on non-read");
	a_block_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind != e2bmw_pkg::K_DONE |-> result.volume_block == 32'd0)
		else $error("block on non-done");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("result without request");
endmodule

bind ext2_block_map_walker e2bmw_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.result(result)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import e2bmw_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t request;
	logic strobe;
	out_item_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	ext2_block_map_walker u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.strobe(strobe), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// walk phases of the predictor
	typedef enum logic [1:0] {PH_IDLE, PH_WAIT_GROUP, PH_WAIT_WORD} walk_phase_e;

	// predictor copy of the registers
	logic [3:0]  m_bs_log2;
	logic [31:0] m_ipg;
	logic [12:0] m_rec_bytes;
	logic        m_first_data;
	// predictor copy of the walk state
	walk_phase_e m_phase;
	logic [1:0]  m_levels;
	logic [31:0] m_rem;
	logic [31:0] m_idx_in_group;
	logic [3:0]  m_slot;

	out_item_t pending_results[$];
	int errors = 0;
	longint cycles = 0;
	localparam longint CYCLE_LIMIT = 2000000;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int eff_log2();
		int maxl;
		maxl = $clog2(MAX_BLOCK_BYTES_DEF + 1) - 1;
		if (m_bs_log2 < 10) return 10;
		if (m_bs_log2 > maxl) return maxl;
		return m_bs_log2;
	endfunction

	function automatic out_item_t mk(logic [1:0] k, logic [63:0] a, logic [31:0] b);
		out_item_t o;
		o.kind = k;
		o.read_address = a[43:0];
		o.volume_block = b;
		return o;
	endfunction

	// computes the translation step for one request and advances the walk state
	function automatic out_item_t walk_step(in_item_t r);
		int bl, cl;
		logic [63:0] n1, n2, n3, x, a;
		logic [31:0] ipg, iidx, idx;
		bl = eff_log2();
		cl = bl - 2;
		if (r.action == 1'b0) begin
			if (m_phase != PH_IDLE || r.ino_num == 0) return mk(K_ERR, 0, 0);
			n1 = 64'd1 << cl;
			n2 = n1 << cl;
			n3 = n2 << cl;
			x = {32'd0, r.file_block};
			if (x < DIRECT_SLOTS_DEF) begin
				m_slot = r.file_block[3:0];
				m_levels = 2'd0;
				m_rem = 0;
			end else begin
				x = x - DIRECT_SLOTS_DEF;
				if (x < n1) begin
					m_slot = 4'(DIRECT_SLOTS_DEF); m_levels = 2'd1;
				end else if (x - n1 < n2) begin
					x = x - n1; m_slot = 4'(DIRECT_SLOTS_DEF + 1); m_levels = 2'd2;
				end else if (x - n1 - n2 < n3) begin
					x = x - n1 - n2; m_slot = 4'(DIRECT_SLOTS_DEF + 2); m_levels = 2'd3;
				end else begin
					return mk(K_RANGE, 0, 0);
				end
				m_rem = x[31:0];
			end
			ipg = (m_ipg == 0) ? 32'd1 : m_ipg;
			iidx = r.ino_num - 1;
			m_idx_in_group = iidx % ipg;
			m_phase = PH_WAIT_GROUP;
			a = (64'(m_first_data + 1) << bl) + 64'(iidx / ipg) * GROUP_DESC_BYTES_DEF
				+ 64'(GD_TABLE_WORD_OFFSET);
			return mk(K_READ, a, 0);
		end
		if (m_phase == PH_WAIT_GROUP) begin
			m_phase = PH_WAIT_WORD;
			a = (64'(r.read_word) << bl) + 64'(m_idx_in_group) * 64'(m_rec_bytes)
				+ 64'(INODE_SLOTS_OFFSET) + 64'(4 * m_slot);
			return mk(K_READ, a, 0);
		end
		if (m_phase == PH_WAIT_WORD) begin
			if (m_levels == 0) begin
				m_phase = PH_IDLE;
				return mk(K_DONE, 0, r.read_word);
			end
			m_levels = m_levels - 2'd1;
			idx = (m_rem >> (cl * m_levels)) & ((32'd1 << cl) - 1);
			return mk(K_READ, (64'(r.read_word) << bl) + 64'(4 * idx), 0);
		end
		return mk(K_ERR, 0, 0);
	endfunction

	// result checker: the receiver cannot stall, so every strobe is taken
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending: kind %0d", result.kind);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result.kind !== want.kind) begin
					$error("kind expected %0d actual %0d", want.kind, result.kind);
					errors++;
				end
				if (result.read_address !== want.read_address) begin
					$error("read_address expected %h actual %h", want.read_address,
						result.read_address);
					errors++;
				end
				if (result.volume_block !== want.volume_block) begin
					$error("volume_block expected %h actual %h", want.volume_block,
						result.volume_block);
					errors++;
				end
			end
		end
	end

	// sender burst shaping
	int burst_left = 0;

	// start stays high between requests of a burst; busy keeps the held request out
	task automatic send(in_item_t r, bit has_fixed, out_item_t fixed);
		out_item_t p;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		p = walk_step(r);
		if (has_fixed && p !== fixed) begin
			$error("table row mismatch: kind expected %0d actual %0d", fixed.kind, p.kind);
			errors++;
		end
		pending_results.push_back(p);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (pending_results.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BLOCK_SIZE_LOG2: m_bs_log2 = val[3:0];
			REG_INODES_PER_GROUP: m_ipg = val;
			REG_INODE_RECORD_BYTES: m_rec_bytes = val[12:0];
			default: m_first_data = val[0];
		endcase
		@(posedge clk);
	endtask

	function automatic in_item_t tr(logic [31:0] ino, logic [31:0] fb);
		in_item_t r;
		r.action = 1'b0;
		r.ino_num = ino;
		r.file_block = fb;
		r.read_word = $urandom;
		return r;
	endfunction

	function automatic in_item_t rd(logic [31:0] w);
		in_item_t r;
		r.action = 1'b1;
		r.ino_num = $urandom;
		r.file_block = $urandom;
		r.read_word = w;
		return r;
	endfunction

	// directed table row
	typedef struct {
		in_item_t req;
		bit has_fixed;
		out_item_t fixed;
	} row_t;

	function automatic logic [31:0] rand_block(int bl);
		int cl;
		cl = bl - 2;
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, DIRECT_SLOTS_DEF - 1);
			1: return DIRECT_SLOTS_DEF + $urandom_range(0, (1 << cl) - 1);
			2: return DIRECT_SLOTS_DEF + (1 << cl) + ($urandom & ((1 << (2 * cl)) - 1));
			3: return $urandom;
			default: return DIRECT_SLOTS_DEF + (1 << cl) + (1 << (2 * cl)) +
				($urandom & ((1 << (3 * cl)) - 1));
		endcase
	endfunction

	task automatic random_phase(int n);
		int sent;
		int steps;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: stray word or random request
				if ($urandom_range(0, 1)) send(rd($urandom), 0, '0);
				else send(tr($urandom, $urandom), 0, '0);
				sent++;
			end else begin
				send(tr($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 40000),
					rand_block(eff_log2())), 0, '0);
				sent++;
				steps = 0;
				while (m_phase != PH_IDLE && steps < 6) begin
					// occasionally break the walk with an overlapping request
					if ($urandom_range(0, 15) == 0) send(tr($urandom, $urandom), 0, '0);
					else send(rd($urandom_range(0, 1) ? $urandom : $urandom_range(0, 5000)),
						0, '0);
					sent++;
					steps++;
				end
			end
		end
		// finish any open walk so the block is idle before register writes
		while (m_phase != PH_IDLE) send(rd($urandom), 0, '0);
		drain();
	endtask

	initial begin
		row_t rows[$];
		row_t rw;
		arst_n = 0;
		start = 0;
		request = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		m_bs_log2 = 4'd10;
		m_ipg = 8192;
		m_rec_bytes = 13'd128;
		m_first_data = 1'b1;
		m_phase = PH_IDLE;
		m_levels = 2'd0;
		m_rem = 0;
		m_idx_in_group = 0;
		m_slot = 4'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults, errors, every slot kind, extremes
		rw.has_fixed = 1; rw.req = rd(32'hFFFFFFFF); rw.fixed = mk(K_ERR, 0, 0); rows.push_back(rw);
		rw.req = tr(0, 5); rw.fixed = mk(K_ERR, 0, 0); rows.push_back(rw);
		rw.req = tr(1, 32'hFFFFFFFF); rw.fixed = mk(K_RANGE, 0, 0); rows.push_back(rw);
		// inode 1 block 0 at reset: group descriptor at block 2, offset 8
		rw.req = tr(1, 0); rw.fixed = mk(K_READ, 64'd2056, 0); rows.push_back(rw);
		rw.req = tr(7, 3); rw.fixed = mk(K_ERR, 0, 0); rows.push_back(rw);
		rw.has_fixed = 0; rw.req = rd(32'd100); rows.push_back(rw);
		rw.has_fixed = 1; rw.req = rd(32'hDEADBEEF); rw.fixed = mk(K_DONE, 0, 32'hDEADBEEF);
		rows.push_back(rw);
		rw.has_fixed = 0;
		rw.req = tr(32'hFFFFFFFF, 11); rows.push_back(rw);
		rw.req = rd(32'hFFFFFFFF); rows.push_back(rw);
		rw.req = rd(0); rows.push_back(rw);
		rw.req = tr(9000, 12); rows.push_back(rw);
		rw.req = rd(5); rows.push_back(rw);
		rw.req = rd(77); rows.push_back(rw);
		rw.req = rd(1234); rows.push_back(rw);
		rw.req = tr(3, 12 + 256); rows.push_back(rw);
		rw.req = rd(1); rows.push_back(rw);
		rw.req = rd(2); rows.push_back(rw);
		rw.req = rd(3); rows.push_back(rw);
		rw.req = rd(4); rows.push_back(rw);
		rw.req = tr(2, 12 + 256 + 65536 + 16777215); rows.push_back(rw);
		repeat (5) begin
			rw.req = rd($urandom); rows.push_back(rw);
		end
		foreach (rows[i]) send(rows[i].req, rows[i].has_fixed, rows[i].fixed);
		drain();

		// settings sweep, extremes included; out-of-range block sizes are clamped
		random_phase(100);
		write_reg(REG_BLOCK_SIZE_LOG2, 12);
		write_reg(REG_INODES_PER_GROUP, 1);
		write_reg(REG_INODE_RECORD_BYTES, 4096);
		write_reg(REG_FIRST_DATA_BLOCK, 0);
		random_phase(130);
		write_reg(REG_BLOCK_SIZE_LOG2, 11);
		write_reg(REG_INODES_PER_GROUP, 32'hFFFFFFFF);
		write_reg(REG_INODE_RECORD_BYTES, 8191);
		random_phase(110);
		write_reg(REG_BLOCK_SIZE_LOG2, 0);
		write_reg(REG_INODES_PER_GROUP, 0);
		write_reg(REG_INODE_RECORD_BYTES, 128);
		write_reg(REG_FIRST_DATA_BLOCK, 1);
		random_phase(110);
		write_reg(REG_BLOCK_SIZE_LOG2, 15);
		write_reg(REG_INODES_PER_GROUP, $urandom_range(1, 3000));
		write_reg(REG_INODE_RECORD_BYTES, 256);
		random_phase(120);
		write_reg(REG_BLOCK_SIZE_LOG2, 10);
		write_reg(REG_INODES_PER_GROUP, $urandom);
		write_reg(REG_INODE_RECORD_BYTES, $urandom);
		write_reg(REG_FIRST_DATA_BLOCK, $urandom);
		random_phase(110);

		if (errors == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
